/* rtl/qrpm_pkg.sv */
// ----------------------------------------------------------------------------
// qrpm_pkg
// Types and constants shared by the quad region pixel mask blocks.
// ----------------------------------------------------------------------------
package qrpm_pkg;

    localparam int COORD_BITS    = 12;
    localparam int VALUE_BITS    = 8;
    localparam int CFG_ADDR_BITS = 4;

    // signed coordinate difference, signed cross product
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
    // sum of four magnitudes, signed difference of two sums
    localparam int SUM_BITS   = CROSS_BITS + 2;
    localparam int DELTA_BITS = SUM_BITS + 1;

    localparam int INSIDE_LIMIT = 4;
    localparam logic [VALUE_BITS-1:0] DETECT_VALUE = VALUE_BITS'(255);

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_LEFT_TOP_X     = 4'd0,
        CFG_LEFT_TOP_Y     = 4'd1,
        CFG_RIGHT_TOP_X    = 4'd2,
        CFG_RIGHT_TOP_Y    = 4'd3,
        CFG_LEFT_BOTTOM_X  = 4'd4,
        CFG_LEFT_BOTTOM_Y  = 4'd5,
        CFG_RIGHT_BOTTOM_X = 4'd6,
        CFG_RIGHT_BOTTOM_Y = 4'd7
    } t_cfg_index;

    typedef struct packed {
        t_coord                pixel_x;
        t_coord                pixel_y;
        logic [VALUE_BITS-1:0] pixel_level;
        logic                  frame_end;
    } t_pix_in;

    typedef struct packed {
        logic [VALUE_BITS-1:0] masked_value;
        logic                  pixel_inside;
        logic                  detection_seen;
        logic                  frame_done;
    } t_pix_out;

    typedef struct packed {
        t_coord lt_x;
        t_coord lt_y;
        t_coord rt_x;
        t_coord rt_y;
        t_coord lb_x;
        t_coord lb_y;
        t_coord rb_x;
        t_coord rb_y;
    } t_quad;

    typedef struct packed {
        logic [3:0][CROSS_BITS-1:0] pix;
        logic [1:0][CROSS_BITS-1:0] quad;
        logic [VALUE_BITS-1:0]      value;
        logic                       frame_end;
    } t_cross;

endpackage

/* rtl/qrpm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// qrpm_cfg_regs
// Quad corner registers, written through a plain write port.
// ----------------------------------------------------------------------------
module qrpm_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qrpm_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  qrpm_pkg::t_coord                  i_cfg_wdata,
    output qrpm_pkg::t_quad                   o_quad
);
    import qrpm_pkg::*;

    t_quad r_quad;
    t_quad n_quad;

    always_comb begin
        n_quad = r_quad;
        if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_LEFT_TOP_X:     n_quad.lt_x = i_cfg_wdata;
                CFG_LEFT_TOP_Y:     n_quad.lt_y = i_cfg_wdata;
                CFG_RIGHT_TOP_X:    n_quad.rt_x = i_cfg_wdata;
                CFG_RIGHT_TOP_Y:    n_quad.rt_y = i_cfg_wdata;
                CFG_LEFT_BOTTOM_X:  n_quad.lb_x = i_cfg_wdata;
                CFG_LEFT_BOTTOM_Y:  n_quad.lb_y = i_cfg_wdata;
                CFG_RIGHT_BOTTOM_X: n_quad.rb_x = i_cfg_wdata;
                CFG_RIGHT_BOTTOM_Y: n_quad.rb_y = i_cfg_wdata;
                default:            n_quad = r_quad;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad <= '0;
        end else begin
            r_quad <= n_quad;
        end
    end

    assign o_quad = r_quad;

endmodule

/* rtl/qrpm_mul_stage.sv */
// ----------------------------------------------------------------------------
// qrpm_mul_stage
// Input register, then the pixel and quad edge cross products into a product register.
// ----------------------------------------------------------------------------
module qrpm_mul_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  qrpm_pkg::t_pix_in i_data,
    input  qrpm_pkg::t_quad   i_quad,
    output logic              o_valid,
    input  logic              i_ready,
    output qrpm_pkg::t_cross  o_data
);
    import qrpm_pkg::*;

    // (b - a) x (c - a)
    function automatic logic signed [CROSS_BITS-1:0] cross2(
        t_coord ax, t_coord ay, t_coord bx, t_coord by, t_coord cx, t_coord cy);
        logic signed [DIFF_BITS-1:0]   ux, uy, vx, vy;
        logic signed [2*DIFF_BITS-1:0] m0, m1;
        ux = $signed({1'b0, bx}) - $signed({1'b0, ax});
        uy = $signed({1'b0, by}) - $signed({1'b0, ay});
        vx = $signed({1'b0, cx}) - $signed({1'b0, ax});
        vy = $signed({1'b0, cy}) - $signed({1'b0, ay});
        m0 = ux * vy;
        m1 = uy * vx;
        return CROSS_BITS'(m0) - CROSS_BITS'(m1);
    endfunction

    logic    r_in_valid;
    t_pix_in r_in;
    logic    r_x_valid;
    t_cross  r_x;
    t_cross  n_x;
    logic    adv_x;
    logic    adv_in;

    assign adv_x  = !r_x_valid || i_ready;
    assign adv_in = !r_in_valid || adv_x;

    always_comb begin
        n_x.pix[0]    = cross2(r_in.pixel_x, r_in.pixel_y, i_quad.lt_x, i_quad.lt_y,
                               i_quad.rt_x, i_quad.rt_y);
        n_x.pix[1]    = cross2(r_in.pixel_x, r_in.pixel_y, i_quad.rt_x, i_quad.rt_y,
                               i_quad.rb_x, i_quad.rb_y);
        n_x.pix[2]    = cross2(r_in.pixel_x, r_in.pixel_y, i_quad.rb_x, i_quad.rb_y,
                               i_quad.lb_x, i_quad.lb_y);
        n_x.pix[3]    = cross2(r_in.pixel_x, r_in.pixel_y, i_quad.lb_x, i_quad.lb_y,
                               i_quad.lt_x, i_quad.lt_y);
        n_x.quad[0]   = cross2(i_quad.lt_x, i_quad.lt_y, i_quad.lb_x, i_quad.lb_y,
                               i_quad.rt_x, i_quad.rt_y);
        n_x.quad[1]   = cross2(i_quad.rt_x, i_quad.rt_y, i_quad.rb_x, i_quad.rb_y,
                               i_quad.lb_x, i_quad.lb_y);
        n_x.value     = r_in.pixel_level;
        n_x.frame_end = r_in.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_x_valid  <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_valid;
            end
            if (adv_x) begin
                r_x_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_valid) begin
            r_in <= i_data;
        end
        if (adv_x && r_in_valid) begin
            r_x <= n_x;
        end
    end

    assign o_ready = adv_in;
    assign o_valid = r_x_valid;
    assign o_data  = r_x;

endmodule

/* rtl/qrpm_test_stage.sv */
// ----------------------------------------------------------------------------
// qrpm_test_stage
// Area sums, inside compare, masking and detection flag into the result register.
// ----------------------------------------------------------------------------
module qrpm_test_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  qrpm_pkg::t_cross   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output qrpm_pkg::t_pix_out o_data
);
    import qrpm_pkg::*;

    logic                         r_out_valid;
    t_pix_out                     r_out;
    t_pix_out                     n_out;
    logic                         r_hit_flag;
    logic                         n_hit_flag;
    logic                         adv;
    logic [3:0][CROSS_BITS-1:0]   pix_mag;
    logic [1:0][CROSS_BITS-1:0]   quad_mag;
    logic [SUM_BITS-1:0]          pix_sum;
    logic [SUM_BITS-1:0]          quad_sum;
    logic signed [DELTA_BITS-1:0] delta;
    logic signed [DELTA_BITS-1:0] limit;
    logic                         in_quad;
    logic                         seen;

    assign adv   = !r_out_valid || i_ready;
    assign limit = DELTA_BITS'(INSIDE_LIMIT);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pix_mag[k] = i_data.pix[k][CROSS_BITS-1] ? (~i_data.pix[k] + 1'b1)
                                                      : i_data.pix[k];
        end
        for (int k = 0; k < 2; k++) begin
            quad_mag[k] = i_data.quad[k][CROSS_BITS-1] ? (~i_data.quad[k] + 1'b1)
                                                        : i_data.quad[k];
        end
        pix_sum  = SUM_BITS'(pix_mag[0]) + SUM_BITS'(pix_mag[1])
                 + SUM_BITS'(pix_mag[2]) + SUM_BITS'(pix_mag[3]);
        quad_sum = SUM_BITS'(quad_mag[0]) + SUM_BITS'(quad_mag[1]);
        delta    = $signed({1'b0, quad_sum}) - $signed({1'b0, pix_sum});
        in_quad  = (delta < limit) && (delta > -limit);
        seen     = r_hit_flag || (in_quad && (i_data.value == DETECT_VALUE));

        n_out.masked_value   = in_quad ? i_data.value : '0;
        n_out.pixel_inside   = in_quad;
        n_out.detection_seen = seen;
        n_out.frame_done     = i_data.frame_end;
        n_hit_flag           = i_data.frame_end ? 1'b0 : seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hit_flag  <= 1'b0;
        end else if (adv) begin
            r_out_valid <= i_valid;
            if (i_valid) begin
                r_hit_flag <= n_hit_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_out <= n_out;
        end
    end

    assign o_ready = adv;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_flag_clears_at_frame_end: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.frame_end) |=> !r_hit_flag
    ) else $error("hit flag not cleared after frame end");

    a_outside_is_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.masked_value != '0)) |-> o_data.pixel_inside
    ) else $error("nonzero value passed while outside");

    a_detect_reported: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.pixel_inside && (o_data.masked_value == DETECT_VALUE))
            |-> o_data.detection_seen
    ) else $error("inside detection not reported");

    a_flag_rise_reported: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hit_flag) |-> (o_valid && o_data.detection_seen && !o_data.frame_done)
    ) else $error("hit flag set without a reported detection");

endmodule

/* rtl/quad_region_pixel_mask.sv */
// ----------------------------------------------------------------------------
// quad_region_pixel_mask
// Masks streamed pixels that fall outside a quad whose four corners are set in the
// corner coordinate registers. A pixel passes through the input register, the cross
// product register and the result register, in that order.
// Throughput: one pixel per cycle; the three register stages stall only on a
// full pipe with the result side not ready.
// Reset clears the corner registers, the detection flag and all stage valids.
// ----------------------------------------------------------------------------
module quad_region_pixel_mask (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  qrpm_pkg::t_pix_in                  i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output qrpm_pkg::t_pix_out                 o_data,
    input  logic                               i_cfg_we,
    input  logic [qrpm_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  qrpm_pkg::t_coord                   i_cfg_wdata
);
    import qrpm_pkg::*;

    t_quad  quad;
    t_cross x_data;
    logic   x_valid;
    logic   x_ready;

    qrpm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_quad      (quad)
    );

    qrpm_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_quad  (quad),
        .o_valid (x_valid),
        .i_ready (x_ready),
        .o_data  (x_data)
    );

    qrpm_test_stage u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (x_valid),
        .o_ready (x_ready),
        .i_data  (x_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
